[src/olist_pkg.sv]
// ============================================================================
// olist_pkg
// shared types and codes for the ordered list engine
// ============================================================================
`default_nettype none

package olist_pkg;

    localparam int OLIST_DEPTH = 32;

    localparam logic [2:0] ACT_PUSH_FRONT = 3'd0;
    localparam logic [2:0] ACT_PUSH_BACK  = 3'd1;
    localparam logic [2:0] ACT_POP_FRONT  = 3'd2;
    localparam logic [2:0] ACT_POP_BACK   = 3'd3;
    localparam logic [2:0] ACT_REMOVE     = 3'd4;
    localparam logic [2:0] ACT_SEARCH     = 3'd5;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_EMPTY   = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;
    localparam logic [1:0] ST_MISSING = 2'd3;

    typedef struct packed {
        logic [2:0]         action;
        logic signed [31:0] data_in;
    } olist_req_t;

    typedef struct packed {
        logic signed [31:0] data_out;
        logic [1:0]         status;
        logic [5:0]         entry_count;
    } olist_rsp_t;

    typedef enum logic [2:0] {
        RD_NONE  = 3'd0,
        RD_FRONT = 3'd1,
        RD_BACK  = 3'd2,
        RD_NEXT  = 3'd3,
        RD_NEXT2 = 3'd4
    } rd_sel_t;

    typedef enum logic [1:0] {
        WR_NONE      = 2'd0,
        WR_FRONT_PRE = 2'd1,
        WR_BACK_POST = 2'd2,
        WR_SHIFT     = 2'd3
    } wr_sel_t;

    typedef enum logic [1:0] {
        DSEL_REQ  = 2'd0,
        DSEL_MEM  = 2'd1,
        DSEL_ZERO = 2'd2
    } dsel_t;

    typedef struct packed {
        logic       load;
        rd_sel_t    rd_sel;
        wr_sel_t    wr_sel;
        logic       idx_clr;
        logic       idx_inc;
        logic       front_inc;
        logic       count_inc;
        logic       count_dec;
        logic       finish;
        logic [1:0] status;
        dsel_t      dsel;
    } olist_cmd_t;

    typedef struct packed {
        logic [2:0] action;
        logic       empty;
        logic       full;
        logic       match;
        logic       scan_last;
        logic       shift_last;
    } olist_stat_t;

endpackage

`default_nettype wire

[src/olist_dp.sv]
// ============================================================================
// olist_dp
// list storage ring, front and count registers, scan index and result beat
// ============================================================================
`default_nettype none

module olist_dp
    import olist_pkg::*;
#(
    parameter int DEPTH = OLIST_DEPTH
)
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  olist_req_t req,
    input  olist_cmd_t cmd,
    output olist_stat_t stat,
    output logic       done,
    output olist_rsp_t rsp
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [CW:0]   DEPTH_X  = (CW + 1)'(DEPTH);
    localparam logic [CW-1:0] DEPTH_C  = CW'(DEPTH);
    localparam logic [AW-1:0] LAST_POS = AW'(DEPTH - 1);
    localparam logic [CW-1:0] TWO_C    = CW'(2);

    function automatic logic [AW-1:0] slot_of(input logic [AW-1:0] base,
                                              input logic [CW-1:0] off);
        logic [CW:0] sum;
        sum = (CW + 1)'(base) + (CW + 1)'(off);
        if (sum >= DEPTH_X)
        begin
            sum = sum - DEPTH_X;
        end
        return sum[AW-1:0];
    endfunction

    logic signed [31:0] mem [DEPTH];

    olist_req_t         req_reg;
    logic [AW-1:0]      front_reg, front_next;
    logic [CW-1:0]      count_reg, count_next;
    logic [AW-1:0]      idx_reg, idx_next;
    logic signed [31:0] rdata_reg;
    olist_rsp_t         rsp_reg, rsp_next;
    logic               done_reg;

    logic [CW-1:0]      idx_ext;
    logic [AW-1:0]      front_dec;
    logic [AW-1:0]      rd_addr, wr_addr;
    logic               rd_en, wr_en;
    logic signed [31:0] wr_data;

    assign idx_ext   = CW'(idx_reg);
    assign front_dec = (front_reg == '0) ? LAST_POS : front_reg - 1'b1;

    always_comb
    begin
        rd_en   = 1'b1;
        rd_addr = front_reg;
        unique case (cmd.rd_sel)
            RD_FRONT: rd_addr = front_reg;
            RD_BACK:  rd_addr = slot_of(front_reg, count_reg - 1'b1);
            RD_NEXT:  rd_addr = slot_of(front_reg, idx_ext + 1'b1);
            RD_NEXT2: rd_addr = slot_of(front_reg, idx_ext + TWO_C);
            default:  rd_en   = 1'b0;
        endcase
    end

    always_comb
    begin
        wr_en   = 1'b1;
        wr_addr = front_dec;
        wr_data = req_reg.data_in;
        unique case (cmd.wr_sel)
            WR_FRONT_PRE: wr_addr = front_dec;
            WR_BACK_POST: wr_addr = slot_of(front_reg, count_reg);
            WR_SHIFT:
            begin
                wr_addr = slot_of(front_reg, idx_ext);
                wr_data = rdata_reg;
            end
            default:      wr_en   = 1'b0;
        endcase
    end

    always_comb
    begin
        front_next = front_reg;
        if (cmd.wr_sel == WR_FRONT_PRE)
        begin
            front_next = front_dec;
        end
        else if (cmd.front_inc)
        begin
            front_next = (front_reg == LAST_POS) ? '0 : front_reg + 1'b1;
        end

        count_next = count_reg;
        if (cmd.count_inc)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (cmd.count_dec)
        begin
            count_next = count_reg - 1'b1;
        end

        idx_next = idx_reg;
        if (cmd.idx_clr)
        begin
            idx_next = '0;
        end
        else if (cmd.idx_inc)
        begin
            idx_next = idx_reg + 1'b1;
        end

        rsp_next.status      = cmd.status;
        rsp_next.entry_count = 6'(count_next);
        case (cmd.dsel)
            DSEL_MEM:  rsp_next.data_out = rdata_reg;
            DSEL_ZERO: rsp_next.data_out = '0;
            default:   rsp_next.data_out = req_reg.data_in;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_reg <= '0;
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            front_reg <= front_next;
            count_reg <= count_next;
            done_reg  <= cmd.finish;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            req_reg <= req;
        end
        idx_reg <= idx_next;
        if (cmd.finish)
        begin
            rsp_reg <= rsp_next;
        end
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rdata_reg <= mem[rd_addr];
        end
    end

    assign stat.action     = req_reg.action;
    assign stat.empty      = (count_reg == '0);
    assign stat.full       = (count_reg == DEPTH_C);
    assign stat.match      = (rdata_reg == req_reg.data_in);
    assign stat.scan_last  = ((idx_ext + 1'b1) == count_reg);
    assign stat.shift_last = ((idx_ext + TWO_C) == count_reg);

    assign done = done_reg;
    assign rsp  = rsp_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= DEPTH_C)
        else $error("entry count above depth");

    a_finish_done: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |=> done_reg)
        else $error("finish without result strobe");

    a_shift_read: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.wr_sel == WR_SHIFT) |-> ($past(cmd.rd_sel) != RD_NONE))
        else $error("compaction write without prior read");

endmodule

`default_nettype wire

[src/olist_ctrl.sv]
// ============================================================================
// olist_ctrl
// sequencer for list actions: decode, pop read, scan and compaction
// ============================================================================
`default_nettype none

module olist_ctrl
    import olist_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  start,
    input  olist_stat_t stat,
    output olist_cmd_t cmd,
    output logic       busy
);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_EXEC  = 5'b00010,
        S_POP   = 5'b00100,
        S_SCAN  = 5'b01000,
        S_SHIFT = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.rd_sel = RD_NONE;
        cmd.wr_sel = WR_NONE;
        cmd.dsel   = DSEL_REQ;
        cmd.status = ST_OK;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                unique case (stat.action) inside
                    ACT_PUSH_FRONT, ACT_PUSH_BACK:
                    begin
                        cmd.finish = 1'b1;
                        state_next = S_IDLE;
                        if (stat.full)
                        begin
                            cmd.status = ST_FULL;
                        end
                        else
                        begin
                            cmd.count_inc = 1'b1;
                            cmd.wr_sel    = (stat.action == ACT_PUSH_FRONT) ?
                                            WR_FRONT_PRE : WR_BACK_POST;
                        end
                    end
                    ACT_POP_FRONT, ACT_POP_BACK:
                    begin
                        if (stat.empty)
                        begin
                            cmd.finish = 1'b1;
                            cmd.status = ST_EMPTY;
                            cmd.dsel   = DSEL_ZERO;
                            state_next = S_IDLE;
                        end
                        else
                        begin
                            cmd.rd_sel = (stat.action == ACT_POP_FRONT) ?
                                         RD_FRONT : RD_BACK;
                            state_next = S_POP;
                        end
                    end
                    ACT_REMOVE, ACT_SEARCH:
                    begin
                        if (stat.empty)
                        begin
                            cmd.finish = 1'b1;
                            cmd.status = (stat.action == ACT_REMOVE) ?
                                         ST_EMPTY : ST_MISSING;
                            state_next = S_IDLE;
                        end
                        else
                        begin
                            cmd.rd_sel  = RD_FRONT;
                            cmd.idx_clr = 1'b1;
                            state_next  = S_SCAN;
                        end
                    end
                    default:
                    begin
                        cmd.finish = 1'b1;
                        state_next = S_IDLE;
                    end
                endcase
            end
            S_POP:
            begin
                cmd.finish    = 1'b1;
                cmd.dsel      = DSEL_MEM;
                cmd.count_dec = 1'b1;
                cmd.front_inc = (stat.action == ACT_POP_FRONT);
                state_next    = S_IDLE;
            end
            S_SCAN:
            begin
                if (stat.match)
                begin
                    if (stat.action == ACT_SEARCH)
                    begin
                        cmd.finish = 1'b1;
                        state_next = S_IDLE;
                    end
                    else if (stat.scan_last)
                    begin
                        cmd.finish    = 1'b1;
                        cmd.count_dec = 1'b1;
                        state_next    = S_IDLE;
                    end
                    else
                    begin
                        cmd.rd_sel = RD_NEXT;
                        state_next = S_SHIFT;
                    end
                end
                else if (stat.scan_last)
                begin
                    cmd.finish = 1'b1;
                    cmd.status = ST_MISSING;
                    state_next = S_IDLE;
                end
                else
                begin
                    cmd.rd_sel  = RD_NEXT;
                    cmd.idx_inc = 1'b1;
                end
            end
            S_SHIFT:
            begin
                cmd.wr_sel = WR_SHIFT;
                if (stat.shift_last)
                begin
                    cmd.finish    = 1'b1;
                    cmd.count_dec = 1'b1;
                    state_next    = S_IDLE;
                end
                else
                begin
                    cmd.rd_sel  = RD_NEXT2;
                    cmd.idx_inc = 1'b1;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = (state_reg != S_IDLE);

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted beat did not raise busy");

    a_finish_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |=> !busy)
        else $error("sequencer not idle after result");

    a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |-> (state_reg == S_IDLE))
        else $error("request captured while busy");

endmodule

`default_nettype wire

[src/ordered_list_engine_unit.sv]
// ============================================================================
// ordered_list_engine_unit
// ordered list of signed words with deque access, search and remove by value
// ============================================================================
// pushes and unknown actions: finished in the exec state; pops: exec reads
// the entry, the pop state returns it; search/remove: exec, then a scan step
// per scanned entry and a shift step per compacted entry, one read per cycle
// busy from accept until the result is registered; next beat may start
// while done is high; results cannot be stalled
// reset empties the list at once, storage contents are not cleared
`default_nettype none

module ordered_list_engine_unit
    import olist_pkg::*;
#(
    parameter int DEPTH = OLIST_DEPTH
)
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  start,
    input  olist_req_t req,
    output logic       busy,
    output logic       done,
    output olist_rsp_t rsp
);

    olist_cmd_t  cmd;
    olist_stat_t stat;

    olist_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy)
    );

    olist_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .cmd   (cmd),
        .stat  (stat),
        .done  (done),
        .rsp   (rsp)
    );

endmodule

`default_nettype wire
